/* rtl/core/tts_pkg.sv */
// Shared types and constants for the two-tap self-synchronizing scrambler.
// Used by tts_cfg, tts_core and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

    localparam int WORD_W = 16;
    localparam int FB_W   = 32;
    localparam int IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_DIRECTION     = 3'd0;
    localparam logic [IDX_W-1:0] REG_GROUP_BITS    = 3'd1;
    localparam logic [IDX_W-1:0] REG_TAP_FIRST     = 3'd2;
    localparam logic [IDX_W-1:0] REG_TAP_SECOND    = 3'd3;
    localparam logic [IDX_W-1:0] REG_OUTPUT_MASK   = 3'd4;
    localparam logic [IDX_W-1:0] REG_REGISTER_MASK = 3'd5;
    localparam logic [IDX_W-1:0] REG_SEED          = 3'd6;

    // Reset values of the configuration registers.
    localparam logic          DIRECTION_RST     = 1'b0;
    localparam logic [4:0]    GROUP_BITS_RST    = 5'd1;
    localparam logic [4:0]    TAP_FIRST_RST     = 5'd18;
    localparam logic [4:0]    TAP_SECOND_RST    = 5'd23;
    localparam logic [15:0]   OUTPUT_MASK_RST   = 16'h0001;
    localparam logic [31:0]   REGISTER_MASK_RST = 32'h007F_FFFF;

    // Direction codes.
    localparam logic DIR_SCRAMBLE   = 1'b0;
    localparam logic DIR_DESCRAMBLE = 1'b1;

    // A group size of six splits the low six bits of the word into two 3-bit groups.
    localparam logic [4:0] SPLIT_GROUP = 5'd6;
    localparam logic [4:0] SPLIT_SHIFT = 5'd3;

    typedef struct packed {
        logic              direction;
        logic [4:0]        group_bits;
        logic [4:0]        tap_first;
        logic [4:0]        tap_second;
        logic [WORD_W-1:0] output_mask;
        logic [FB_W-1:0]   register_mask;
    } cfg_t;

    // Seed write: loads the feedback register.
    typedef struct packed {
        logic            load;
        logic [FB_W-1:0] value;
    } seed_t;

    // Occupancy of the two pipeline stages.
    typedef struct packed {
        logic in_valid;
        logic out_valid;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/core/tts_cfg.sv */
// Configuration register file of the scrambler: decodes the write port.
// Depends on tts_pkg for the register indexes, reset values and types.
`timescale 1ns / 1ps
`default_nettype none

module tts_cfg (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wen,
    input  wire logic [tts_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [tts_pkg::FB_W-1:0]  cfg_wdata,
    output tts_pkg::cfg_t                  cfg,
    output tts_pkg::seed_t                 seed
);

    tts_pkg::cfg_t cfg_reg;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.direction     <= tts_pkg::DIRECTION_RST;
            cfg_reg.group_bits    <= tts_pkg::GROUP_BITS_RST;
            cfg_reg.tap_first     <= tts_pkg::TAP_FIRST_RST;
            cfg_reg.tap_second    <= tts_pkg::TAP_SECOND_RST;
            cfg_reg.output_mask   <= tts_pkg::OUTPUT_MASK_RST;
            cfg_reg.register_mask <= tts_pkg::REGISTER_MASK_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                tts_pkg::REG_DIRECTION:     cfg_reg.direction     <= cfg_wdata[0];
                tts_pkg::REG_GROUP_BITS:    cfg_reg.group_bits    <= cfg_wdata[4:0];
                tts_pkg::REG_TAP_FIRST:     cfg_reg.tap_first     <= cfg_wdata[4:0];
                tts_pkg::REG_TAP_SECOND:    cfg_reg.tap_second    <= cfg_wdata[4:0];
                tts_pkg::REG_OUTPUT_MASK:   cfg_reg.output_mask   <= cfg_wdata[15:0];
                tts_pkg::REG_REGISTER_MASK: cfg_reg.register_mask <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // A seed write goes straight to the feedback register in the core.
    assign seed.load  = cfg_wen && (cfg_index == tts_pkg::REG_SEED);
    assign seed.value = cfg_wdata;

endmodule

`default_nettype wire

/* rtl/core/tts_core.sv */
// Scrambler datapath: input stage, feedback register, group logic, output stage.
// Depends on tts_pkg for the configuration, seed and status types.
`timescale 1ns / 1ps
`default_nettype none

module tts_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire tts_pkg::cfg_t              cfg,
    input  wire tts_pkg::seed_t             seed,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [tts_pkg::WORD_W-1:0] s_tdata,
    input  wire logic                       s_tlast,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [tts_pkg::WORD_W-1:0]      m_tdata,
    output logic                            m_tlast,
    output tts_pkg::stat_t                  stat
);

    typedef struct packed {
        logic [tts_pkg::WORD_W-1:0] y;
        logic [tts_pkg::FB_W-1:0]   r;
    } step_t;

    // One group: XOR with both taps, mask, then shift the register and feed back.
    function automatic step_t group_step(
        input logic [tts_pkg::FB_W-1:0]   r,
        input logic [tts_pkg::WORD_W-1:0] x,
        input logic [4:0]                 shift,
        input tts_pkg::cfg_t              c
    );
        step_t                    s;
        logic [tts_pkg::FB_W-1:0] taps;
        logic [tts_pkg::FB_W-1:0] fb;
        taps = (r >> c.tap_first) ^ (r >> c.tap_second);
        s.y  = (x ^ taps[tts_pkg::WORD_W-1:0]) & c.output_mask;
        fb   = (c.direction == tts_pkg::DIR_DESCRAMBLE) ? {16'h0000, x} : {16'h0000, s.y};
        s.r  = ((r << shift) & c.register_mask) | fb;
        return s;
    endfunction

    logic                       in_valid_reg;
    logic [tts_pkg::WORD_W-1:0] in_word_reg;
    logic                       in_last_reg;
    logic                       out_valid_reg;
    logic [tts_pkg::WORD_W-1:0] out_word_reg;
    logic                       out_last_reg;
    logic [tts_pkg::FB_W-1:0]   fb_reg;
    logic [tts_pkg::FB_W-1:0]   fb_next;
    logic [tts_pkg::WORD_W-1:0] out_word_next;

    logic  advance;
    logic  s_xfer;
    logic  split;
    step_t step_a;
    step_t step_b;

    // The input stage moves on whenever the output stage is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    // Group logic: one pass for the whole word, or two chained 3-bit groups.
    always_comb begin
        split  = (cfg.group_bits == tts_pkg::SPLIT_GROUP);
        step_a = group_step(fb_reg,
                            split ? {13'h0000, in_word_reg[5:3]} : in_word_reg,
                            split ? tts_pkg::SPLIT_SHIFT : cfg.group_bits,
                            cfg);
        step_b = group_step(step_a.r, {13'h0000, in_word_reg[2:0]},
                            tts_pkg::SPLIT_SHIFT, cfg);
        if (split) begin
            out_word_next = {step_a.y[12:0], 3'b000} | step_b.y;
            fb_next       = step_b.r;
        end else begin
            out_word_next = step_a.y;
            fb_next       = step_a.r;
        end
    end

    // Input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_word_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Feedback register: a seed write loads it, each word advances it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_reg <= '0;
        end else if (seed.load) begin
            fb_reg <= seed.value;
        end else if (advance) begin
            fb_reg <= fb_next;
        end
    end

    // Output stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= out_word_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_word_reg;
    assign m_tlast        = out_last_reg;
    assign stat.in_valid  = in_valid_reg;
    assign stat.out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/two_tap_self_sync_scrambler_unit.sv */
// Top level of the two-tap self-synchronizing scrambler / descrambler.
// Instantiates tts_cfg and tts_core; depends on tts_pkg.
//
//   Channel   Ports                                 Direction  Contents
//   input     s_tvalid s_tready s_tdata s_tlast     in         word to process, batch mark
//   result    m_tvalid m_tready m_tdata m_tlast     out        processed word, batch mark
//   config    cfg_wen cfg_index cfg_wdata           in         register writes, no read-back
//
// One word per cycle while m_tready is high; a word passes the input, then output
// stage. The rate is set by the feedback register, which takes one update per word.
// Reset is synchronous and active low: it empties both stages, clears the feedback
// register and restores the register defaults. When the result side stalls, the
// input stage still takes one more word, then s_tready drops until m_tready returns.
`timescale 1ns / 1ps
`default_nettype none

module two_tap_self_sync_scrambler_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [tts_pkg::WORD_W-1:0] s_tdata,   // [15:0] in_word
    input  wire logic                       s_tlast,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [tts_pkg::WORD_W-1:0]      m_tdata,   // [15:0] out_word
    output logic                            m_tlast,
    input  wire logic                       cfg_wen,
    input  wire logic [tts_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [tts_pkg::FB_W-1:0]   cfg_wdata
);

    tts_pkg::cfg_t  cfg;
    tts_pkg::seed_t seed;
    tts_pkg::stat_t stat;

    tts_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .seed      (seed)
    );

    tts_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .seed     (seed),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .stat     (stat)
    );

    // An empty input stage always takes a transfer.
    a_free_input_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !stat.in_valid |-> s_tready)
        else $error("input stage empty but s_tready low");

    // An accepted transfer occupies the input stage in the next cycle.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> stat.in_valid)
        else $error("accepted word lost from the input stage");

    // With both stages full and the result side stalled, nothing is dropped.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.in_valid && stat.out_valid && !m_tready) |=> (stat.in_valid && stat.out_valid))
        else $error("word dropped during a result stall");

endmodule

`default_nettype wire

/* verif/tb_two_tap_self_sync_scrambler_unit.sv */
// Self-checking testbench for two_tap_self_sync_scrambler_unit.
// A built-in predictor of the scrambler computes each expected word, with random bursts
// and receiver stalls. Depends on tts_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_two_tap_self_sync_scrambler_unit;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int RANDOM_PHASES = 14;
    localparam int WORDS_PER_PHASE = 100;
    // Index 7 lies beyond the register list and must be ignored.
    localparam logic [tts_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [tts_pkg::WORD_W-1:0] word;
        logic                       last;
    } scr_word_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_LONG_STALL
    } ready_mode_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [tts_pkg::WORD_W-1:0] s_tdata = '0;    // [15:0] in_word
    logic                       s_tlast = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [tts_pkg::WORD_W-1:0] m_tdata;         // [15:0] out_word
    logic                       m_tlast;
    logic                       cfg_wen = 1'b0;
    logic [tts_pkg::IDX_W-1:0]  cfg_index = '0;
    logic [tts_pkg::FB_W-1:0]   cfg_wdata = '0;

    // Predictor state: configuration and feedback register.
    tts_pkg::cfg_t            pred_cfg;
    logic [tts_pkg::FB_W-1:0] pred_fb;

    scr_word_t   expected_words[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          sender_idling = 1'b1;
    ready_mode_t ready_mode = READY_ALWAYS;
    int          ready_mode_left = 0;

    two_tap_self_sync_scrambler_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Free-running clock, 20 ns period.
    initial begin
        forever #10 aclk = ~aclk;
    end

    // One group through the two taps; advances the predicted feedback register.
    function automatic logic [tts_pkg::WORD_W-1:0] scramble_group(
        input logic [tts_pkg::FB_W-1:0] x,
        input logic [4:0]               shift
    );
        logic [tts_pkg::FB_W-1:0]   r;
        logic [tts_pkg::FB_W-1:0]   mix;
        logic [tts_pkg::WORD_W-1:0] y;
        r = pred_fb;
        mix = x ^ (r >> pred_cfg.tap_first) ^ (r >> pred_cfg.tap_second);
        y = mix[tts_pkg::WORD_W-1:0] & pred_cfg.output_mask;
        pred_fb = ((r << shift) & pred_cfg.register_mask)
                  | ((pred_cfg.direction == tts_pkg::DIR_DESCRAMBLE) ? x : {16'h0000, y});
        return y;
    endfunction

    // Expected result of one input word, split into two 3-bit groups for size six.
    function automatic scr_word_t scramble_word(input logic [tts_pkg::WORD_W-1:0] w,
                                                input logic l);
        scr_word_t                  res;
        logic [tts_pkg::WORD_W-1:0] hi_res;
        logic [tts_pkg::WORD_W-1:0] lo_res;
        if (pred_cfg.group_bits == tts_pkg::SPLIT_GROUP) begin
            hi_res = scramble_group({29'd0, w[5:3]}, tts_pkg::SPLIT_SHIFT);
            lo_res = scramble_group({29'd0, w[2:0]}, tts_pkg::SPLIT_SHIFT);
            res.word = (hi_res << 3) | lo_res;
        end else begin
            res.word = scramble_group({16'h0000, w}, pred_cfg.group_bits);
        end
        res.last = l;
        return res;
    endfunction

    task automatic note_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Mirror register writes and input transfers, and check every result transfer.
    always @(posedge aclk) begin
        scr_word_t exp_word;
        if (!aresetn) begin
            pred_cfg.direction     = tts_pkg::DIRECTION_RST;
            pred_cfg.group_bits    = tts_pkg::GROUP_BITS_RST;
            pred_cfg.tap_first     = tts_pkg::TAP_FIRST_RST;
            pred_cfg.tap_second    = tts_pkg::TAP_SECOND_RST;
            pred_cfg.output_mask   = tts_pkg::OUTPUT_MASK_RST;
            pred_cfg.register_mask = tts_pkg::REGISTER_MASK_RST;
            pred_fb                = '0;
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    tts_pkg::REG_DIRECTION:     pred_cfg.direction     = cfg_wdata[0];
                    tts_pkg::REG_GROUP_BITS:    pred_cfg.group_bits    = cfg_wdata[4:0];
                    tts_pkg::REG_TAP_FIRST:     pred_cfg.tap_first     = cfg_wdata[4:0];
                    tts_pkg::REG_TAP_SECOND:    pred_cfg.tap_second    = cfg_wdata[4:0];
                    tts_pkg::REG_OUTPUT_MASK:   pred_cfg.output_mask   = cfg_wdata[15:0];
                    tts_pkg::REG_REGISTER_MASK: pred_cfg.register_mask = cfg_wdata;
                    tts_pkg::REG_SEED:          pred_fb                = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_words.push_back(scramble_word(s_tdata, s_tlast));
            end
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    note_failure($sformatf("unexpected word %h last %b", m_tdata, m_tlast));
                end else begin
                    exp_word = expected_words.pop_front();
                    if (m_tdata !== exp_word.word || m_tlast !== exp_word.last) begin
                        note_failure($sformatf("expected word %h last %b, got word %h last %b",
                                               exp_word.word, exp_word.last, m_tdata, m_tlast));
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_two_tap_self_sync_scrambler_unit NOT OK");
            $finish;
        end
    end

    // Receiver: ready follows a randomly drawn mode, redrawn when its random run length ends.
    always @(negedge aclk) begin
        if (ready_mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            ready_mode_left = $urandom_range(20, 200);
        end else begin
            ready_mode_left--;
        end
        case (ready_mode)
            READY_ALWAYS:     m_tready <= 1'b1;
            READY_COIN:       m_tready <= 1'($urandom_range(0, 1));
            READY_LONG_STALL: m_tready <= ($urandom_range(0, 15) == 0);
            default:          m_tready <= 1'b1;
        endcase
    end

    // Offer one word and hold it until the transfer; gaps fall between bursts.
    task automatic send_word(input logic [tts_pkg::WORD_W-1:0] w, input logic l);
        int gap;
        if (sender_idling && burst_left == 0) begin
            gap = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 32);
            if (gap != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        if (burst_left != 0) burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait until every expected word has come out.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [tts_pkg::IDX_W-1:0] idx,
                             input logic [tts_pkg::FB_W-1:0] value);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        @(negedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    // Write every register; the seed goes last and loads the feedback register.
    task automatic set_config(input logic dir, input logic [4:0] grp, input logic [4:0] t1,
                              input logic [4:0] t2, input logic [15:0] omask,
                              input logic [31:0] rmask, input logic [31:0] seed_value);
        wait_idle();
        write_reg(tts_pkg::REG_DIRECTION, {31'd0, dir});
        write_reg(tts_pkg::REG_GROUP_BITS, {27'd0, grp});
        write_reg(tts_pkg::REG_TAP_FIRST, {27'd0, t1});
        write_reg(tts_pkg::REG_TAP_SECOND, {27'd0, t2});
        write_reg(tts_pkg::REG_OUTPUT_MASK, {16'h0000, omask});
        write_reg(tts_pkg::REG_REGISTER_MASK, rmask);
        write_reg(tts_pkg::REG_SEED, seed_value);
    endtask

    // Defaults after reset: one-bit groups, one output bit, zero register.
    task automatic test_reset_defaults();
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h8000, 1'b0);
        send_word(16'h0001, 1'b1);
    endtask

    // Descrambler feeds back all 16 input bits, with extreme taps and masks.
    task automatic test_descramble_whole_word();
        set_config(tts_pkg::DIR_DESCRAMBLE, 5'd16, 5'd0, 5'd31, 16'hFFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hA5A5, 1'b1);
    endtask

    // A group size of zero keeps the masked register and ORs in the feedback.
    task automatic test_group_zero();
        set_config(tts_pkg::DIR_SCRAMBLE, 5'd0, 5'd3, 5'd9, 16'hFFFF, 32'h00FF_FFFF,
                   32'h1234_5678);
        send_word(16'h5A5A, 1'b0);
        send_word(16'hC3C3, 1'b1);
    endtask

    // Group sizes above 16 are used as the shift unchanged.
    task automatic test_group_wide();
        set_config(tts_pkg::DIR_SCRAMBLE, 5'd31, 5'd1, 5'd2, 16'hFFFF, 32'hFFFF_FFFF,
                   32'hDEAD_BEEF);
        send_word(16'h0F0F, 1'b0);
        send_word(16'hF0F0, 1'b0);
        set_config(tts_pkg::DIR_DESCRAMBLE, 5'd17, 5'd4, 5'd13, 16'h7FFF, 32'h0FFF_FFFF,
                   32'h8000_0001);
        send_word(16'h1357, 1'b1);
        send_word(16'hFFFE, 1'b0);
    endtask

    // Split mode: two 3-bit groups; zero tap lets the first group overflow when packed.
    task automatic test_split_groups();
        set_config(tts_pkg::DIR_SCRAMBLE, tts_pkg::SPLIT_GROUP, 5'd0, 5'd5, 16'hFFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(16'h003F, 1'b0);
        send_word(16'hFFC0, 1'b1);
        set_config(tts_pkg::DIR_DESCRAMBLE, tts_pkg::SPLIT_GROUP, 5'd18, 5'd23, 16'h0007,
                   32'h007F_FFFF, 32'h0055_AA55);
        send_word(16'h0015, 1'b0);
        send_word(16'h002A, 1'b1);
    endtask

    // A write beyond the register list changes nothing; a second seed write reloads.
    task automatic test_bad_index_and_reseed();
        wait_idle();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_word(16'h0024, 1'b0);
        wait_idle();
        write_reg(tts_pkg::REG_SEED, 32'h0000_0000);
        write_reg(tts_pkg::REG_SEED, 32'hCAFE_F00D);
        send_word(16'h0009, 1'b1);
    endtask

    // Random phases, each with its own configuration; first and second use the extremes.
    task automatic test_random_traffic();
        logic        dir;
        logic [4:0]  grp;
        logic [4:0]  t1;
        logic [4:0]  t2;
        logic [15:0] omask;
        logic [31:0] rmask;
        logic [31:0] seed_value;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                dir = 1'b0; grp = 5'd0; t1 = 5'd0; t2 = 5'd0;
                omask = 16'h0000; rmask = 32'h0000_0000; seed_value = 32'h0000_0000;
            end else if (phase == 1) begin
                dir = 1'b1; grp = 5'd31; t1 = 5'd31; t2 = 5'd31;
                omask = 16'hFFFF; rmask = 32'hFFFF_FFFF; seed_value = 32'hFFFF_FFFF;
            end else begin
                dir = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0, 1:    grp = tts_pkg::SPLIT_GROUP;
                    2:       grp = 5'($urandom_range(1, 16));
                    default: grp = 5'($urandom_range(0, 31));
                endcase
                t1 = 5'($urandom_range(0, 31));
                t2 = 5'($urandom_range(0, 31));
                case ($urandom_range(0, 2))
                    0:       omask = 16'hFFFF;
                    1:       omask = 16'($urandom);
                    default: omask = 16'(1 << $urandom_range(0, 15)) - 16'd1;
                endcase
                case ($urandom_range(0, 2))
                    0:       rmask = tts_pkg::REGISTER_MASK_RST;
                    1:       rmask = 32'hFFFF_FFFF;
                    default: rmask = $urandom;
                endcase
                seed_value = $urandom;
            end
            set_config(dir, grp, t1, t2, omask, rmask, seed_value);
            if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
            // Every fourth phase runs back to back without sender gaps.
            sender_idling = (phase % 4 != 3);
            burst_left = 0;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                send_word(16'($urandom), ($urandom_range(0, 7) == 0));
            end
        end
        sender_idling = 1'b1;
    endtask

    // Test sequence: reset once, directed cases, random traffic, then drain.
    initial begin
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_descramble_whole_word();
        test_group_zero();
        test_group_wide();
        test_split_groups();
        test_bad_index_and_reseed();
        test_random_traffic();

        wait_idle();
        repeat (8) @(posedge aclk);
        if (expected_words.size() != 0) begin
            note_failure($sformatf("%0d expected words never arrived", expected_words.size()));
        end
        if (mismatch_count == 0) begin
            $display("tb_two_tap_self_sync_scrambler_unit OK");
        end else begin
            $display("tb_two_tap_self_sync_scrambler_unit NOT OK");
        end
        $finish;
    end

endmodule
